// File: hw/rtl/schs_pkg.sv
// types, request and status codes shared by the card hand store modules
package schs_pkg;

    localparam int HAND_SIZE = 8;
    localparam int IDX_W     = (HAND_SIZE > 1) ? $clog2(HAND_SIZE) : 1;
    localparam int CNT_W     = $clog2(HAND_SIZE + 1);
    localparam int KEY_W     = 6;
    localparam int VALUE_W   = 4;
    localparam int SUIT_W    = 2;
    localparam int SLOT_W    = 3;
    localparam int REQ_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 4;

    localparam logic [REQ_W-1:0] REQ_INSERT    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REM_MATCH = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REM_SLOT  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_SLOT  = 2'd3;

    // sort key: value in the upper bits, suit in the lower bits
    typedef logic [KEY_W-1:0] card_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic              enable;
        logic [REQ_W-1:0]  op;
        card_t             key;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  count;
        logic              full;
        logic              found;
        logic              slot_ok;
    } cell_cmd_t;

endpackage

// File: hw/rtl/sorted_card_hand_store.sv
// top level of the sorted card hand store: cell row, count and result register
//
//  channel  | dir | tdata (low bit up)                           | tuser
//  s_       | in  | card_value[3:0] card_suit[5:4] slot_idx[8:6] | req_type[1:0]
//  m_       | out | out_value[3:0] out_suit[5:4] card_count[9:6] | status[1:0]
//
// one item per cycle while s_tready is high: every cell compares and shifts in the cycle of acceptance
// the result appears in the output register in the cycle after acceptance
// aresetn clears the count and the output valid; cell contents are not reset
// s_tready is high while the output register is empty or being taken
module sorted_card_hand_store import schs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // card_value, card_suit, slot_index
    input  logic [1:0]  s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_value, out_suit, card_count
    output logic [1:0]  m_tuser    // status
);

    logic                accept;
    logic [REQ_W-1:0]    req_type;
    logic [VALUE_W-1:0]  card_value;
    logic [SUIT_W-1:0]   card_suit;
    logic [SLOT_W-1:0]   slot_index;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    card_t               removed_reg;
    card_t               removed_next;
    logic [COUNT_W-1:0]  card_count_reg;

    cell_cmd_t           cmd;
    card_t               entry_vec [HAND_SIZE];
    logic [HAND_SIZE-1:0] le_vec;
    logic [HAND_SIZE-1:0] eq_vec;

    assign req_type   = s_tuser[1:0];
    assign card_value = s_tdata[3:0];
    assign card_suit  = s_tdata[5:4];
    assign slot_index = s_tdata[8:6];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd.enable  = accept;
        cmd.op      = req_type;
        cmd.key     = {card_value, card_suit};
        cmd.slot    = slot_index;
        cmd.count   = count_reg;
        cmd.full    = int'(count_reg) >= HAND_SIZE;
        cmd.found   = |eq_vec;
        cmd.slot_ok = int'(slot_index) < int'(count_reg);
    end

    for (genvar i = 0; i < HAND_SIZE; i++) begin : g_cell
        card_t left_entry;
        logic  left_le;
        card_t right_entry;

        if (i == 0) begin : g_first
            assign left_entry = '0;
            assign left_le    = 1'b1;
        end else begin : g_mid
            assign left_entry = entry_vec[i-1];
            assign left_le    = le_vec[i-1];
        end

        if (i == HAND_SIZE - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_upper
            assign right_entry = entry_vec[i+1];
        end

        schs_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .cell_idx    (IDX_W'(i)),
            .left_entry  (left_entry),
            .left_le     (left_le),
            .right_entry (right_entry),
            .entry       (entry_vec[i]),
            .le          (le_vec[i]),
            .eq          (eq_vec[i])
        );
    end

    always_comb begin
        count_next   = count_reg;
        status_next  = ST_OK;
        removed_next = '0;
        case (req_type)
            REQ_INSERT: begin
                if (cmd.full) begin
                    status_next = ST_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            REQ_REM_MATCH: begin
                if (cmd.found) begin
                    removed_next = cmd.key;
                    count_next   = count_reg - 1'b1;
                end else begin
                    status_next = ST_NOT_FOUND;
                end
            end
            REQ_REM_SLOT: begin
                if (cmd.slot_ok) begin
                    removed_next = entry_vec[IDX_W'(slot_index)];
                    count_next   = count_reg - 1'b1;
                end else begin
                    status_next = ST_BAD_SLOT;
                end
            end
            REQ_CLEAR: begin
                count_next = '0;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg     <= status_next;
            removed_reg    <= removed_next;
            card_count_reg <= COUNT_W'(count_next);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {6'd0, card_count_reg, removed_reg[SUIT_W-1:0],
                       removed_reg[KEY_W-1:SUIT_W]};

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(count_reg) <= HAND_SIZE)
        else $error("card count above hand size");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid_reg |-> s_tready)
        else $error("input stalled with empty output register");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && req_type == REQ_CLEAR) |=> (count_reg == '0 && card_count_reg == '0))
        else $error("clear left cards behind");

    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && req_type == REQ_INSERT && int'(count_reg) >= HAND_SIZE)
        |=> (status_reg == ST_FULL && $stable(count_reg)))
        else $error("insert into full list changed the count");
`endif

endmodule

// File: hw/rtl/schs_cell.sv
// one slot of the sorted row: holds a card and shifts to or from its neighbors
module schs_cell import schs_pkg::*; (
    input  logic             aclk,
    input  cell_cmd_t        cmd,
    input  logic [IDX_W-1:0] cell_idx,
    input  card_t            left_entry,
    input  logic             left_le,
    input  card_t            right_entry,
    output card_t            entry,
    output logic             le,
    output logic             eq
);

    card_t entry_reg;
    card_t entry_next;
    logic  valid;
    logic  lt;

    assign valid = int'(cell_idx) < int'(cmd.count);
    assign le    = valid && (entry_reg <= cmd.key);
    assign lt    = valid && (entry_reg < cmd.key);
    assign eq    = valid && (entry_reg == cmd.key);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        case (cmd.op)
            REQ_INSERT: begin
                // cells past the insert point take their left neighbor; the first of them takes the new key
                if (!cmd.full && !le) begin
                    entry_next = left_le ? cmd.key : left_entry;
                end
            end
            REQ_REM_MATCH: begin
                // sorted row: the match and everything above it close up
                if (cmd.found && !lt) begin
                    entry_next = right_entry;
                end
            end
            REQ_REM_SLOT: begin
                if (cmd.slot_ok && int'(cell_idx) >= int'(cmd.slot)) begin
                    entry_next = right_entry;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.enable) begin
            entry_reg <= entry_next;
        end
    end

endmodule
